### design/assert_macros.svh
// Assertion helpers shared by the allocator modules.
// Every check is sampled on the rising clock edge and is off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that holds on every enabled clock edge.
`define BFA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/bfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

	// Request kinds.
	localparam logic KIND_FREE  = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_REUSED   = 3'd0;
	localparam logic [2:0] ST_APPENDED = 3'd1;
	localparam logic [2:0] ST_STORED   = 3'd2;
	localparam logic [2:0] ST_DROPPED  = 3'd3;
	localparam logic [2:0] ST_WRAPPED  = 3'd4;

	typedef struct packed {
		logic        kind;
		logic [15:0] request_size;
		logic [31:0] block_offset;
	} bfa_in_t;

	typedef struct packed {
		logic [31:0] granted_offset;
		logic [2:0]  status;
	} bfa_out_t;

	typedef enum logic {
		BFA_IDLE,
		BFA_EXEC
	} bfa_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} bfa_cmd_t;

endpackage

`default_nettype wire

### design/bfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bfa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	output bfa_pkg::bfa_cmd_t     cmd
);

	bfa_pkg::bfa_state_t state_q;
	bfa_pkg::bfa_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::BFA_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		busy      = 1'b0;
		cmd       = '0;
		case (state_q)
			bfa_pkg::BFA_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = bfa_pkg::BFA_EXEC;
				end
			end
			bfa_pkg::BFA_EXEC: begin
				busy      = 1'b1;
				cmd.exec  = 1'b1;
				state_nxt = bfa_pkg::BFA_IDLE;
			end
			default: begin
				state_nxt = bfa_pkg::BFA_IDLE;
			end
		endcase
	end

	`BFA_ASSERT_NEXT(a_load_then_exec, clk, arst_n, cmd.load, cmd.exec && busy, "load not followed by exec")
	`BFA_ASSERT_NEXT(a_exec_one_cycle, clk, arst_n, cmd.exec, !busy, "exec lasted more than one cycle")

endmodule

`default_nettype wire

### design/bfa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bfa_datapath #(
	parameter int LIST_DEPTH  = 16,
	parameter int SIZE_BITS   = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bfa_pkg::bfa_cmd_t cmd,
	input  wire bfa_pkg::bfa_in_t  request,
	output bfa_pkg::bfa_out_t      result,
	output logic                   done
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int SUM_W = ((OFFSET_BITS > SIZE_BITS) ? OFFSET_BITS : SIZE_BITS) + 1;

	// Latched request, trimmed to the configured widths.
	logic                   kind_q;
	logic [SIZE_BITS-1:0]   req_size_q;
	logic [OFFSET_BITS-1:0] req_off_q;

	// Sorted cell chain; only the first count_q cells hold live pairs.
	logic [SIZE_BITS-1:0]   cell_size_q [LIST_DEPTH];
	logic [OFFSET_BITS-1:0] cell_off_q  [LIST_DEPTH];
	logic [SIZE_BITS-1:0]   cell_size_nxt [LIST_DEPTH];
	logic [OFFSET_BITS-1:0] cell_off_nxt  [LIST_DEPTH];
	logic [CNT_W-1:0]       count_q;
	logic [OFFSET_BITS-1:0] endp_q;

	logic [LIST_DEPTH-1:0]  valid;
	logic [LIST_DEPTH-1:0]  after;
	logic [LIST_DEPTH-1:0]  fit;
	logic [LIST_DEPTH-1:0]  first;
	logic                   full;
	logic                   hit;
	logic [OFFSET_BITS-1:0] hit_off;
	logic [SUM_W-1:0]       sum;
	logic                   wrap;

	logic [SIZE_BITS+15:0]   size_wide;
	logic [OFFSET_BITS+31:0] off_wide;
	logic [OFFSET_BITS-1:0]  grant;
	logic [OFFSET_BITS+31:0] grant_wide;
	logic [2:0]              status_nxt;

	bfa_pkg::bfa_out_t result_q;
	logic              done_q;

	assign size_wide = {{SIZE_BITS{1'b0}}, request.request_size};
	assign off_wide  = {{OFFSET_BITS{1'b0}}, request.block_offset};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= request.kind;
			req_size_q <= size_wide[SIZE_BITS-1:0];
			req_off_q  <= off_wide[OFFSET_BITS-1:0];
		end
	end

	// Every cell compares itself with the request; both flag vectors are
	// monotone over the live cells because the list is kept sorted.
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			valid[i] = CNT_W'(i) < count_q;
			after[i] = valid[i] && ((cell_size_q[i] > req_size_q) ||
				((cell_size_q[i] == req_size_q) && (cell_off_q[i] > req_off_q)));
			fit[i]   = valid[i] && (cell_size_q[i] >= req_size_q);
		end
	end

	always_comb begin
		hit_off  = '0;
		first[0] = fit[0];
		for (int i = 1; i < LIST_DEPTH; i++) begin
			first[i] = fit[i] && !fit[i-1];
		end
		for (int i = 0; i < LIST_DEPTH; i++) begin
			hit_off = hit_off | ({OFFSET_BITS{first[i]}} & cell_off_q[i]);
		end
	end

	assign full = (count_q == CNT_W'(LIST_DEPTH));
	assign hit  = |fit;
	assign sum  = SUM_W'(endp_q) + SUM_W'(req_size_q);
	assign wrap = |sum[SUM_W-1:OFFSET_BITS];

	// Next cell contents: shift up behind the insert point, or down from the hit.
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			cell_size_nxt[i] = cell_size_q[i];
			cell_off_nxt[i]  = cell_off_q[i];
		end
		if (kind_q == bfa_pkg::KIND_FREE) begin
			if (!full) begin
				if (after[0] || !valid[0]) begin
					cell_size_nxt[0] = req_size_q;
					cell_off_nxt[0]  = req_off_q;
				end
				for (int i = 1; i < LIST_DEPTH; i++) begin
					if (after[i-1]) begin
						cell_size_nxt[i] = cell_size_q[i-1];
						cell_off_nxt[i]  = cell_off_q[i-1];
					end else if ((after[i] || !valid[i]) && valid[i-1]) begin
						cell_size_nxt[i] = req_size_q;
						cell_off_nxt[i]  = req_off_q;
					end
				end
			end
		end else begin
			for (int i = 0; i < LIST_DEPTH - 1; i++) begin
				if (fit[i]) begin
					cell_size_nxt[i] = cell_size_q[i+1];
					cell_off_nxt[i]  = cell_off_q[i+1];
				end
			end
		end
	end

	always_comb begin
		grant = '0;
		if (kind_q == bfa_pkg::KIND_FREE) begin
			status_nxt = full ? bfa_pkg::ST_DROPPED : bfa_pkg::ST_STORED;
		end else if (hit) begin
			grant      = hit_off;
			status_nxt = bfa_pkg::ST_REUSED;
		end else begin
			grant      = endp_q;
			status_nxt = wrap ? bfa_pkg::ST_WRAPPED : bfa_pkg::ST_APPENDED;
		end
	end

	assign grant_wide = {32'd0, grant};

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				cell_size_q[i] <= cell_size_nxt[i];
				cell_off_q[i]  <= cell_off_nxt[i];
			end
			result_q.granted_offset <= grant_wide[31:0];
			result_q.status         <= status_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			endp_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				if (kind_q == bfa_pkg::KIND_FREE) begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end else if (hit) begin
					count_q <= count_q - CNT_W'(1);
				end else begin
					endp_q <= sum[OFFSET_BITS-1:0];
				end
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

	`BFA_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(LIST_DEPTH), "list count beyond depth")
	`BFA_ASSERT_NEXT(a_drop_when_full, clk, arst_n, cmd.exec && (kind_q == bfa_pkg::KIND_FREE) && full, (result_q.status == bfa_pkg::ST_DROPPED) && (count_q == $past(count_q)), "full list free not dropped")
	`BFA_ASSERT_NEXT(a_reuse_shrinks, clk, arst_n, cmd.exec && (kind_q == bfa_pkg::KIND_ALLOC) && hit, count_q == $past(count_q) - CNT_W'(1), "reused slot not removed")

endmodule

`default_nettype wire

### design/best_fit_free_list_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                  Transaction taken when
// --------  ---------------------  ---------------------------------------
// request   start, busy, request   rising edge with start high, busy low
// result    done, result           rising edge ending the cycle done is high
//
// Each transaction captures the request in the load step; then, in the exec
// step, every cell of the sorted list compares itself with it and the chain
// shifts, after which the result register holds the answer.
// A new request is taken in the cycle that the result is shown; none is taken
// while busy is high for the compare and shift step of the cell chain.
// Reset is asynchronous and active low; it empties the list and clears the
// end pointer. The receiver cannot stall, so done is a one-cycle strobe.

module best_fit_free_list_allocator #(
	parameter int LIST_DEPTH  = 16,
	parameter int SIZE_BITS   = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bfa_pkg::bfa_in_t request,
	output bfa_pkg::bfa_out_t     result,
	output logic                  done
);

	// Command bundle from the sequencer into the list datapath.
	bfa_pkg::bfa_cmd_t cmd;

	bfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The datapath holds the sorted (size, offset) cells, the live count and
	// the end pointer, and registers each result before it is shown.
	bfa_datapath #(
		.LIST_DEPTH  (LIST_DEPTH),
		.SIZE_BITS   (SIZE_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result),
		.done    (done)
	);

endmodule

`default_nettype wire
